// File: hdl/pvpg_pkg.sv
// Shared types, constants and the arctangent step table for the phyllotaxis point generator.
`default_nettype none
package pvpg_pkg;

   localparam int DEG_HALF_TURN = 180;

   // Full turn in degrees with 16 fraction bits.
   localparam logic [24:0] FULL_TURN_Q16 = 25'((2 * DEG_HALF_TURN) << 16);

   // Fold thresholds in degrees with 24 fraction bits.
   localparam logic [32:0] Z_QUARTER   = 33'(64'(DEG_HALF_TURN / 2) << 24);
   localparam logic [32:0] Z_HALF      = 33'(64'(DEG_HALF_TURN) << 24);
   localparam logic [32:0] Z_THREE_QTR = 33'(64'(DEG_HALF_TURN * 3 / 2) << 24);
   localparam logic [32:0] Z_FULL      = 33'(64'(DEG_HALF_TURN * 2) << 24);

   localparam logic [23:0] GAIN_Q24 = 24'd10188014;
   localparam logic [63:0] RAD_TO_DEG_Q24 = 64'd961263669;

   localparam int DIV_STEPS  = 41;   // quotient bits 40..0 of n*2^40/d
   localparam int ANG_STEPS  = 12;   // bits of n in the angle product
   localparam int SQRT_STEPS = 21;   // root bits of a 41-bit radicand

   // Register indexes of the configuration port.
   localparam logic [2:0] CSR_CENTER_X    = 3'd0;
   localparam logic [2:0] CSR_CENTER_Y    = 3'd1;
   localparam logic [2:0] CSR_RADIUS      = 3'd2;
   localparam logic [2:0] CSR_POINT_COUNT = 3'd3;
   localparam logic [2:0] CSR_START_POINT = 3'd4;
   localparam logic [2:0] CSR_ANGLE_DEG   = 3'd5;

   // Control that travels with an item between units.
   typedef struct packed {
      logic        vld;
      logic        ok;
      logic        flip;
      logic [32:0] z;     // signed residual angle, degrees Q24
   } side_type;

   // atan(2^-i) in degrees, 24 fraction bits.
   function automatic logic [31:0] atan_step(input int i);
      logic [31:0] v;
      unique case (i)
         0:       v = 32'd754974720;
         1:       v = 32'd445687602;
         2:       v = 32'd235489088;
         3:       v = 32'd119537938;
         4:       v = 32'd60000934;
         5:       v = 32'd30029717;
         6:       v = 32'd15018523;
         7:       v = 32'd7509720;
         8:       v = 32'd3754917;
         9:       v = 32'd1877466;
         10:      v = 32'd938734;
         default: v = 32'((RAD_TO_DEG_Q24 + (64'd1 << (i - 1))) >> i);
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// File: hdl/pvpg_front.sv
// Restoring divider for n*2^40/d with the angle product reduced modulo one turn alongside.
`default_nettype none
module pvpg_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                in_vld,
   input  wire logic                in_ok,
   input  wire logic [11:0]         in_n,
   input  wire logic [11:0]         in_d,
   input  wire logic [24:0]         angle_deg,
   output pvpg_pkg::side_type       out_side,
   output logic [40:0]              out_quo
);

   typedef struct packed {
      logic        vld;
      logic        ok;
      logic [11:0] n;
      logic [11:0] d;
      logic [11:0] rem;
      logic [40:0] quo;
      logic [24:0] acc;
      logic        flip;
      logic [32:0] z;
   } fst_type;

   localparam int NST = pvpg_pkg::DIV_STEPS;

   logic [24:0] ang_r;
   fst_type     head;
   fst_type     prv   [NST];
   fst_type     st_in [NST];
   fst_type     st_ff [NST];

   // Angle register may reach past one turn; one subtract brings it below.
   assign ang_r = (angle_deg >= pvpg_pkg::FULL_TURN_Q16) ?
                  angle_deg - pvpg_pkg::FULL_TURN_Q16 : angle_deg;

   always_comb begin
      head     = '0;
      head.vld = in_vld;
      head.ok  = in_ok;
      head.n   = in_n;
      head.d   = in_d;
   end

   for (genvar k = 0; k < NST; k++) begin : g_st
      localparam int NB = (k < pvpg_pkg::ANG_STEPS) ? pvpg_pkg::ANG_STEPS - 1 - k : 0;

      if (k == 0) begin : g_src0
         assign prv[k] = head;
      end else begin : g_srcn
         assign prv[k] = st_ff[k-1];
      end

      always_comb begin
         fst_type     nx;
         logic [12:0] rem2;
         logic        qb;
         logic [26:0] acc2;
         nx   = prv[k];
         rem2 = (k == 0) ? {1'b0, prv[k].n} : {prv[k].rem, 1'b0};
         qb   = rem2 >= {1'b0, prv[k].d};
         nx.rem = qb ? 12'(rem2 - {1'b0, prv[k].d}) : rem2[11:0];
         nx.quo = {prv[k].quo[39:0], qb};
         acc2 = '0;
         if (k < pvpg_pkg::ANG_STEPS) begin
            // acc = (2*acc + bit*angle) mod turn, MSB of n first
            acc2 = {1'b0, prv[k].acc, 1'b0} +
                   (prv[k].n[NB] ? {2'b0, ang_r} : 27'd0);
            if (acc2 >= {2'b0, pvpg_pkg::FULL_TURN_Q16}) begin
               acc2 = acc2 - {2'b0, pvpg_pkg::FULL_TURN_Q16};
            end
            if (acc2 >= {2'b0, pvpg_pkg::FULL_TURN_Q16}) begin
               acc2 = acc2 - {2'b0, pvpg_pkg::FULL_TURN_Q16};
            end
            nx.acc = acc2[24:0];
         end
         if (k == pvpg_pkg::ANG_STEPS) begin
            // fold into [-90, 90]; middle half turn flips the result
            nx.z    = {prv[k].acc, 8'b0};
            nx.flip = 1'b0;
            if (nx.z > pvpg_pkg::Z_THREE_QTR) begin
               nx.z = nx.z - pvpg_pkg::Z_FULL;
            end else if (nx.z > pvpg_pkg::Z_QUARTER) begin
               nx.z    = nx.z - pvpg_pkg::Z_HALF;
               nx.flip = 1'b1;
            end
         end
         st_in[k] = nx;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff[k].vld <= 1'b0;
         end else if (en) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign out_side.vld  = st_ff[NST-1].vld;
   assign out_side.ok   = st_ff[NST-1].ok;
   assign out_side.flip = st_ff[NST-1].flip;
   assign out_side.z    = st_ff[NST-1].z;
   assign out_quo       = st_ff[NST-1].quo;

endmodule
`default_nettype wire

// File: hdl/pvpg_sqrt.sv
// Pipelined bitwise integer square root, one result bit per stage.
`default_nettype none
module pvpg_sqrt (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  pvpg_pkg::side_type       in_side,
   input  wire logic [40:0]         in_t,
   output pvpg_pkg::side_type       out_side,
   output logic [20:0]              out_root
);

   typedef struct packed {
      pvpg_pkg::side_type side;
      logic [41:0]        t;
      logic [41:0]        res;
   } sst_type;

   localparam int NST = pvpg_pkg::SQRT_STEPS;

   sst_type prv   [NST];
   sst_type st_in [NST];
   sst_type st_ff [NST];

   for (genvar k = 0; k < NST; k++) begin : g_st
      localparam logic [41:0] BIT = 42'(1) << (2 * (NST - 1 - k));

      if (k == 0) begin : g_src0
         assign prv[k].side = in_side;
         assign prv[k].t    = {1'b0, in_t};
         assign prv[k].res  = '0;
      end else begin : g_srcn
         assign prv[k] = st_ff[k-1];
      end

      always_comb begin
         logic [41:0] trial;
         st_in[k] = prv[k];
         trial    = prv[k].res + BIT;
         if (prv[k].t >= trial) begin
            st_in[k].t   = prv[k].t - trial;
            st_in[k].res = (prv[k].res >> 1) + BIT;
         end else begin
            st_in[k].res = prv[k].res >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff[k].side.vld <= 1'b0;
         end else if (en) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign out_side = st_ff[NST-1].side;
   assign out_root = st_ff[NST-1].res[20:0];

endmodule
`default_nettype wire

// File: hdl/pvpg_cordic.sv
// Pipelined CORDIC rotation in degrees, one micro-rotation per stage.
`default_nettype none
module pvpg_cordic #(
   parameter int ITERATIONS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  pvpg_pkg::side_type       in_side,
   input  wire logic [38:0]         in_x,
   output pvpg_pkg::side_type       out_side,
   output logic [41:0]              out_x,
   output logic [41:0]              out_y
);

   typedef struct packed {
      pvpg_pkg::side_type side;
      logic [41:0]        x;
      logic [41:0]        y;
   } cst_type;

   cst_type prv   [ITERATIONS];
   cst_type st_in [ITERATIONS];
   cst_type st_ff [ITERATIONS];

   for (genvar i = 0; i < ITERATIONS; i++) begin : g_st
      localparam logic [31:0] ATAN = pvpg_pkg::atan_step(i);

      if (i == 0) begin : g_src0
         assign prv[i].side = in_side;
         assign prv[i].x    = {3'b0, in_x};
         assign prv[i].y    = '0;
      end else begin : g_srcn
         assign prv[i] = st_ff[i-1];
      end

      always_comb begin
         logic signed [41:0] dx;
         logic signed [41:0] dy;
         logic signed [32:0] zs;
         dx = $signed(prv[i].y) >>> i;
         dy = $signed(prv[i].x) >>> i;
         zs = $signed(prv[i].side.z);
         st_in[i] = prv[i];
         if (zs >= 0) begin
            st_in[i].x      = 42'($signed(prv[i].x) - dx);
            st_in[i].y      = 42'($signed(prv[i].y) + dy);
            st_in[i].side.z = 33'(zs - $signed({1'b0, ATAN}));
         end else begin
            st_in[i].x      = 42'($signed(prv[i].x) + dx);
            st_in[i].y      = 42'($signed(prv[i].y) - dy);
            st_in[i].side.z = 33'(zs + $signed({1'b0, ATAN}));
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff[i].side.vld <= 1'b0;
         end else if (en) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   assign out_side = st_ff[ITERATIONS-1].side;
   assign out_x    = st_ff[ITERATIONS-1].x;
   assign out_y    = st_ff[ITERATIONS-1].y;

endmodule
`default_nettype wire

// File: hdl/phyllotaxis_point_generator_unit.sv
// Throughput: one item per cycle; every stage is a register with a valid bit.
// A stall at the output freezes the pipe only while the output register is full.
// Reset (synchronous, high) empties the pipe and loads the register reset values.
// The configuration port always takes writes (csr_ready is tied high).
`default_nettype none
module phyllotaxis_point_generator_unit #(
   parameter int MAX_POINTS        = 1024,
   parameter int CORDIC_ITERATIONS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [9:0]  req_point_index,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_x_out,
   output logic [31:0]      rsp_y_out,
   output logic             rsp_index_valid,
   // configuration channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   // ---------------- configuration registers ----------------
   logic [31:0] center_x_ff;
   logic [31:0] center_y_ff;
   logic [30:0] radius_ff;
   logic [10:0] point_count_ff;
   logic [10:0] start_point_ff;
   logic [24:0] angle_deg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff    <= '0;
         center_y_ff    <= '0;
         radius_ff      <= 31'd65536;
         point_count_ff <= 11'd256;
         start_point_ff <= 11'd1;
         angle_deg_ff   <= 25'd9011200;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pvpg_pkg::CSR_CENTER_X:    center_x_ff    <= csr_wdata;
            pvpg_pkg::CSR_CENTER_Y:    center_y_ff    <= csr_wdata;
            pvpg_pkg::CSR_RADIUS:      radius_ff      <= csr_wdata[30:0];
            pvpg_pkg::CSR_POINT_COUNT: point_count_ff <= csr_wdata[10:0];
            pvpg_pkg::CSR_START_POINT: start_point_ff <= csr_wdata[10:0];
            pvpg_pkg::CSR_ANGLE_DEG:   angle_deg_ff   <= csr_wdata[24:0];
            default: ;  // unknown index: dropped
         endcase
      end
   end

   // ---------------- pipeline enable ----------------
   // Every stage moves together; only a held, full output register stops it.
   logic en;
   logic out_vld_ff;

   assign en        = !(out_vld_ff && rsp_stall);
   assign req_stall = !en;

   // ---------------- input register ----------------
   logic       in_vld_ff;
   logic [9:0] in_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (en) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in_idx_ff <= req_point_index;
      end
   end

   // ---------------- list geometry ----------------
   // count is clamped to MAX_POINTS; a zero start point counts as one.
   logic [10:0] count;
   logic [10:0] s;
   logic [11:0] n;
   logic [11:0] last;
   logic [11:0] d;
   logic        ok;

   assign count = (32'(point_count_ff) > MAX_POINTS) ? 11'(MAX_POINTS) : point_count_ff;
   assign ok    = {1'b0, in_idx_ff} < count;
   assign s     = (start_point_ff == 11'd0) ? 11'd0 : start_point_ff - 11'd1;
   assign n     = 12'(s) + 12'(in_idx_ff);
   assign last  = 12'(s) + 12'(count);
   assign d     = (last > 12'd2) ? last - 12'd1 : 12'd1;

   // ---------------- divide and angle reduction ----------------
   pvpg_pkg::side_type div_side;
   logic [40:0]        div_quo;

   pvpg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_vld    (in_vld_ff),
      .in_ok     (ok),
      .in_n      (n),
      .in_d      (d),
      .angle_deg (angle_deg_ff),
      .out_side  (div_side),
      .out_quo   (div_quo)
   );

   // ---------------- square root: ratio q in Q.20 ----------------
   pvpg_pkg::side_type sq_side;
   logic [20:0]        sq_root;

   pvpg_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_side  (div_side),
      .in_t     (div_quo),
      .out_side (sq_side),
      .out_root (sq_root)
   );

   // ---------------- radius scale, then CORDIC gain ----------------
   pvpg_pkg::side_type ma_side_ff;
   logic [30:0]        r_ff;
   logic [51:0]        prod_a;
   pvpg_pkg::side_type mb_side_ff;
   logic [38:0]        x0_ff;
   logic [54:0]        prod_b;

   assign prod_a = 52'(radius_ff) * 52'(sq_root);
   assign prod_b = 55'(r_ff) * 55'(pvpg_pkg::GAIN_Q24);

   always_ff @(posedge clock) begin
      if (reset) begin
         ma_side_ff.vld <= 1'b0;
         mb_side_ff.vld <= 1'b0;
      end else if (en) begin
         ma_side_ff <= sq_side;
         mb_side_ff <= ma_side_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff  <= prod_a[50:20];
         x0_ff <= prod_b[54:16];
      end
   end

   // ---------------- rotation ----------------
   pvpg_pkg::side_type cr_side;
   logic [41:0]        cr_x;
   logic [41:0]        cr_y;

   pvpg_cordic #(
      .ITERATIONS (CORDIC_ITERATIONS)
   ) u_cordic (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_side  (mb_side_ff),
      .in_x     (x0_ff),
      .out_side (cr_side),
      .out_x    (cr_x),
      .out_y    (cr_y)
   );

   // ---------------- half-turn flip ----------------
   logic        pf_vld_ff;
   logic        pf_ok_ff;
   logic [41:0] pf_x_ff;
   logic [41:0] pf_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pf_vld_ff <= 1'b0;
      end else if (en) begin
         pf_vld_ff <= cr_side.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pf_ok_ff <= cr_side.ok;
         pf_x_ff  <= cr_side.flip ? 42'(-$signed(cr_x)) : cr_x;
         pf_y_ff  <= cr_side.flip ? 42'(-$signed(cr_y)) : cr_y;
      end
   end

   // ---------------- round to Q16.16, add center, saturate ----------------
   logic signed [41:0] xr_sum;
   logic signed [41:0] yr_sum;
   logic signed [33:0] xr;
   logic signed [33:0] yr;
   logic signed [34:0] xo;
   logic signed [34:0] yo;
   logic [31:0]        x_sat;
   logic [31:0]        y_sat;

   assign xr_sum = $signed(pf_x_ff) + 42'sd128;
   assign yr_sum = $signed(pf_y_ff) + 42'sd128;
   assign xr     = 34'(xr_sum >>> 8);
   assign yr     = 34'(yr_sum >>> 8);
   assign xo     = 35'(xr) + 35'($signed(center_x_ff));
   assign yo     = 35'(yr) + 35'($signed(center_y_ff));

   always_comb begin
      if (xo > 35'sh0_7FFF_FFFF) begin
         x_sat = 32'h7FFF_FFFF;
      end else if (xo < -35'sh0_8000_0000) begin
         x_sat = 32'h8000_0000;
      end else begin
         x_sat = xo[31:0];
      end
      if (yo > 35'sh0_7FFF_FFFF) begin
         y_sat = 32'h7FFF_FFFF;
      end else if (yo < -35'sh0_8000_0000) begin
         y_sat = 32'h8000_0000;
      end else begin
         y_sat = yo[31:0];
      end
   end

   // ---------------- output register ----------------
   logic [31:0] x_out_ff;
   logic [31:0] y_out_ff;
   logic        ivalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= pf_vld_ff;
      end
   end

   // Indices outside the list report zero coordinates.
   always_ff @(posedge clock) begin
      if (en) begin
         ivalid_ff <= pf_ok_ff;
         x_out_ff  <= pf_ok_ff ? x_sat : 32'd0;
         y_out_ff  <= pf_ok_ff ? y_sat : 32'd0;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_x_out       = x_out_ff;
   assign rsp_y_out       = y_out_ff;
   assign rsp_index_valid = ivalid_ff;

`ifndef SYNTHESIS
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_index_valid) |-> (rsp_x_out == 32'd0 && rsp_y_out == 32'd0))
      else $error("out-of-list item carries nonzero coordinates");

   a_empty_out_accepts: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("intake stalled with an empty output register");

   a_pipe_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(pf_x_ff) && $stable(pf_vld_ff))
      else $error("pipeline advanced while output held");
`endif

endmodule
`default_nettype wire

// File: dv/phyllotaxis_point_generator_unit_tb.sv
// Self-checking bench for the phyllotaxis point generator: directed table, random points, predictor.
`default_nettype none
module phyllotaxis_point_generator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_PTS   = 1024;
   localparam int CORDIC_IT = 16;
   localparam int PIPE_LAT  = 67 + CORDIC_IT;
   localparam longint CYCLE_LIMIT = 2_000_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [9:0]  req_point_index = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_x_out;
   logic [31:0] rsp_y_out;
   logic        rsp_index_valid;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   phyllotaxis_point_generator_unit #(
      .MAX_POINTS(MAX_PTS),
      .CORDIC_ITERATIONS(CORDIC_IT)
   ) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_point_index(req_point_index),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_x_out(rsp_x_out),
      .rsp_y_out(rsp_y_out), .rsp_index_valid(rsp_index_valid),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic        ok;
   } point_type;

   // Shadow copy of the register file
   logic signed [31:0] sh_cx, sh_cy;
   logic [30:0] sh_radius;
   logic [10:0] sh_count, sh_start;
   logic [24:0] sh_angle;

   point_type pending_points[$];
   bit        failed = 1'b0;
   longint    cycle_count = 0;
   int        idle_pct = 34;   // dropped to 0 during the no-idle stretch

   function automatic logic [63:0] root64(input logic [63:0] t_in);
      logic [63:0] t, res, bit_w;
      t = t_in; res = '0; bit_w = 64'd1 << 62;
      for (int k = 0; k < 32; k++) begin
         if (t >= res + bit_w) begin
            t = t - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res = res >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return res;
   endfunction

   function automatic longint arctan_deg(input int i);
      longint tab[11] = '{754974720, 445687602, 235489088, 119537938, 60000934,
                          30029717, 15018523, 7509720, 3754917, 1877466, 938734};
      if (i < 11) return tab[i];
      return longint'((64'd961263669 + (64'd1 << (i - 1))) >> i);
   endfunction

   function automatic logic [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   // Computes the spiral point for one list position from the shadow registers.
   function automatic point_type spiral_point(input logic [9:0] idx);
      point_type p;
      logic [63:0] cnt, s, n, last, d, q, r, a;
      longint z, x, y, dx, dy, xo, yo;
      bit flip;
      cnt = (sh_count > MAX_PTS) ? MAX_PTS : sh_count;
      p = '0;
      if (idx >= cnt) return p;
      flip = 1'b0;
      s = (sh_start != 0) ? sh_start - 1 : 0;
      n = s + idx;
      last = s + cnt;
      d = (last > 2) ? last - 1 : 1;
      q = root64((n << 40) / d);
      r = (64'(sh_radius) * q) >> 20;
      a = (n * 64'(sh_angle)) % (64'd360 << 16);
      z = longint'(a) * 256;
      if (z > (longint'(270) << 24)) z -= longint'(360) << 24;
      else if (z > (longint'(90) << 24)) begin
         z -= longint'(180) << 24;
         flip = 1'b1;
      end
      x = longint'((r * 64'd10188014) >> 16);
      y = 0;
      for (int i = 0; i < CORDIC_IT; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx; y = y + dy; z -= arctan_deg(i);
         end else begin
            x = x + dx; y = y - dy; z += arctan_deg(i);
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      xo = ((x + 128) >>> 8) + longint'(sh_cx);
      yo = ((y + 128) >>> 8) + longint'(sh_cy);
      p.x = clamp32(xo);
      p.y = clamp32(yo);
      p.ok = 1'b1;
      return p;
   endfunction

   // Cycle counter doubles as the watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Result side: random stall, compare each accepted item with the oldest prediction
   always @(posedge clock) begin
      point_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_points.size() == 0) begin
            $display("%0t: unexpected point x=%h y=%h ok=%b", $time, rsp_x_out,
                     rsp_y_out, rsp_index_valid);
            failed = 1'b1;
         end else begin
            e = pending_points.pop_front();
            if (rsp_x_out !== e.x) begin
               $display("%0t: x_out expected %h actual %h", $time, e.x, rsp_x_out);
               failed = 1'b1;
            end
            if (rsp_y_out !== e.y) begin
               $display("%0t: y_out expected %h actual %h", $time, e.y, rsp_y_out);
               failed = 1'b1;
            end
            if (rsp_index_valid !== e.ok) begin
               $display("%0t: index_valid expected %b actual %b", $time, e.ok,
                        rsp_index_valid);
               failed = 1'b1;
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < idle_pct);
   end

   // One register write while the pipe is empty; the shadow copy follows it.
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         pvpg_pkg::CSR_CENTER_X:    sh_cx = val;
         pvpg_pkg::CSR_CENTER_Y:    sh_cy = val;
         pvpg_pkg::CSR_RADIUS:      sh_radius = val[30:0];
         pvpg_pkg::CSR_POINT_COUNT: sh_count = val[10:0];
         pvpg_pkg::CSR_START_POINT: sh_start = val[10:0];
         pvpg_pkg::CSR_ANGLE_DEG:   sh_angle = val[24:0];
         default: ;
      endcase
   endtask

   // Sends one item; the prediction is queued at the accepting edge.
   // valid stays up after the accept so items can follow back to back.
   task automatic send_index(input logic [9:0] idx, input bit use_typed,
                             input point_type typed);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_point_index <= idx;
      do @(posedge clock); while (req_stall);
      pending_points.push_back(use_typed ? typed : spiral_point(idx));
   endtask

   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 10) @(posedge clock);
   endtask

   // Directed rows: register to write (or none), index, and an optional typed result
   typedef struct {
      bit          do_write;
      logic [2:0]  reg_idx;
      logic [31:0] reg_val;
      logic [9:0]  index;
      bit          typed;
      point_type   want;
   } step_row_type;

   localparam point_type OUT_OF_LIST = '{x: 32'h0, y: 32'h0, ok: 1'b0};
   localparam point_type ORIGIN_PT   = '{x: 32'h0, y: 32'h0, ok: 1'b1};
   localparam point_type NONE        = '{x: 32'h0, y: 32'h0, ok: 1'b0};

   step_row_type directed[] = '{
      // after reset: index 0 sits at radius zero on the center
      '{0, pvpg_pkg::CSR_CENTER_X, 0, 10'd0, 1, ORIGIN_PT},
      '{0, pvpg_pkg::CSR_CENTER_X, 0, 10'd1, 0, NONE},
      '{0, pvpg_pkg::CSR_CENTER_X, 0, 10'd255, 0, NONE},
      '{0, pvpg_pkg::CSR_CENTER_X, 0, 10'd256, 1, OUT_OF_LIST},
      '{0, pvpg_pkg::CSR_CENTER_X, 0, 10'd1023, 1, OUT_OF_LIST},
      // empty list
      '{1, pvpg_pkg::CSR_POINT_COUNT, 0, 10'd0, 1, OUT_OF_LIST},
      // count above the limit, full index range
      '{1, pvpg_pkg::CSR_POINT_COUNT, 32'h7FF, 10'd1023, 0, NONE},
      '{0, pvpg_pkg::CSR_CENTER_X, 0, 10'd512, 0, NONE},
      // start point zero acts as one
      '{1, pvpg_pkg::CSR_START_POINT, 0, 10'd0, 1, ORIGIN_PT},
      '{1, pvpg_pkg::CSR_START_POINT, 32'h7FF, 10'd3, 0, NONE},
      '{1, pvpg_pkg::CSR_START_POINT, 1024, 10'd1023, 0, NONE},
      // angle above and at a full turn, then zero and a quarter turn
      '{1, pvpg_pkg::CSR_ANGLE_DEG, 32'h1FF_FFFF, 10'd700, 0, NONE},
      '{1, pvpg_pkg::CSR_ANGLE_DEG, 23592960, 10'd77, 0, NONE},
      '{1, pvpg_pkg::CSR_ANGLE_DEG, 0, 10'd9, 0, NONE},
      '{1, pvpg_pkg::CSR_ANGLE_DEG, 5898240, 10'd5, 0, NONE},
      // saturation at the extremes
      '{1, pvpg_pkg::CSR_RADIUS, 32'hFFFF_FFFF, 10'd1023, 0, NONE},
      '{1, pvpg_pkg::CSR_CENTER_X, 32'h7FFF_FFFF, 10'd1000, 0, NONE},
      '{1, pvpg_pkg::CSR_CENTER_Y, 32'h8000_0000, 10'd333, 0, NONE},
      '{1, pvpg_pkg::CSR_CENTER_X, 32'h8000_0000, 10'd600, 0, NONE},
      '{1, pvpg_pkg::CSR_CENTER_Y, 32'h7FFF_FFFF, 10'd1022, 0, NONE},
      '{1, pvpg_pkg::CSR_RADIUS, 0, 10'd10, 0, NONE},
      // unknown register index is ignored
      '{1, 3'd7, 32'hDEAD_BEEF, 10'd1, 0, NONE},
      '{1, 3'd6, 32'h1234_5678, 10'd2, 0, NONE}
   };

   // Random register value, extremes weighted in
   function automatic logic [31:0] pick_value(input logic [2:0] idx);
      int sel;
      sel = $urandom_range(9);
      case (idx)
         pvpg_pkg::CSR_CENTER_X, pvpg_pkg::CSR_CENTER_Y:
            return (sel == 0) ? 32'h7FFF_FFFF : (sel == 1) ? 32'h8000_0000 :
                   (sel < 5) ? 32'($signed($urandom_range(200) - 100) <<< 16) : $urandom;
         pvpg_pkg::CSR_RADIUS:
            return (sel == 0) ? 32'h7FFF_FFFF : (sel == 1) ? 32'h0 :
                   (sel < 6) ? $urandom_range(32'h0064_0000) : $urandom;
         pvpg_pkg::CSR_POINT_COUNT:
            return (sel == 0) ? 0 : (sel == 1) ? 1024 : (sel == 2) ? 32'h7FF :
                   (sel == 3) ? 1 : $urandom_range(1024);
         pvpg_pkg::CSR_START_POINT:
            return (sel == 0) ? 0 : (sel == 1) ? 1024 : (sel == 2) ? 32'h7FF :
                   $urandom_range(1, 1024);
         default:
            return (sel == 0) ? 32'h1FF_FFFF : (sel == 1) ? 0 :
                   (sel < 8) ? $urandom_range(23592959) : $urandom;
      endcase
   endfunction

   initial begin
      int idx_cap;
      sh_cx = 0; sh_cy = 0; sh_radius = 31'd65536;
      sh_count = 11'd256; sh_start = 11'd1; sh_angle = 25'd9011200;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part; every write lands on an idle pipe
      foreach (directed[k]) begin
         if (directed[k].do_write) begin
            drain_pipe();
            write_reg(directed[k].reg_idx, directed[k].reg_val);
         end
         send_index(directed[k].index, directed[k].typed, directed[k].want);
      end

      // Random phases: new settings, then a burst of indices
      for (int ph = 0; ph < 30; ph++) begin
         drain_pipe();
         if (ph == 0) begin
            for (int r = 0; r < 6; r++) write_reg(3'(r), pick_value(3'(r)));
         end else begin
            repeat ($urandom_range(1, 3)) begin
               logic [2:0] ri;
               ri = 3'($urandom_range(5));
               write_reg(ri, pick_value(ri));
            end
         end
         idle_pct = (ph == 10 || ph == 20) ? 0 : 34;
         // mostly in-list indices, the rest anywhere
         idx_cap = (sh_count == 0) ? 0 : ((sh_count > MAX_PTS) ? MAX_PTS : sh_count) - 1;
         repeat (50) begin
            if ($urandom_range(9) < 8) send_index(10'($urandom_range(idx_cap)), 0, NONE);
            else send_index(10'($urandom), 0, NONE);
         end
         idle_pct = 34;
      end

      drain_pipe();
      if (!failed) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
`default_nettype wire
